/* rtl/core/sscnt_pkg.sv */
// sscnt_pkg: shared constants, action codes and controller/datapath
// interface types for the substring occurrence counter.
// No dependencies.
package sscnt_pkg;

    // Longest pattern, and the text window depth
    localparam int MAX_PATTERN = 128;
    // Address width of the pattern and text memories
    localparam int AW = $clog2(MAX_PATTERN);
    // Width of a length or fill count (0 .. MAX_PATTERN)
    localparam int LW = $clog2(MAX_PATTERN + 1);
    // Text memory depth, a power of two so the write pointer wraps by itself
    localparam int TXT_DEPTH = 1 << AW;
    // Result counter
    localparam int CW = 16;
    localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
    localparam logic [LW-1:0] LEN_MAX = LW'(MAX_PATTERN);

    // Input action codes
    typedef enum logic [1:0] {
        ACT_CLEAR   = 2'd0,
        ACT_PATTERN = 2'd1,
        ACT_TEXT    = 2'd2
    } t_action;

    // Controller to datapath commands
    typedef struct packed {
        logic          clear;      // new query: drop pattern, fill, count
        logic          pat_wr;     // append pattern byte
        logic          txt_wr;     // push text byte into the window
        logic          cmp_clear;  // reset mismatch flag before a compare pass
        logic          rd_en;      // read one pattern/window byte pair
        logic [AW-1:0] rd_idx;     // pattern index of the pair
        logic          inc;        // count one occurrence
        logic          emit;       // load result register, clear count and fill
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic can_match;  // pattern non-empty and window holds enough bytes
        logic last_rd;    // rd_idx addresses the final pattern byte
        logic mismatch;   // a byte pair differed in this compare pass
    } t_stat;

endpackage

/* rtl/core/substring_occurrence_counter.sv */
// Counts overlapping occurrences of a loaded pattern in a text stream.
// Channels: input word (action, symbol, last) and result word (match_count),
// both valid/ready.
// A query opens with a clear word, then pattern bytes, then text bytes; the
// text byte flagged last yields one result, the saturating 16-bit count,
// after which the count and window restart and the pattern is kept.
// Clear and pattern words are taken in the idle state. A text byte runs
// start and done when no compare is possible (empty pattern or window not
// yet full enough), else start, compare, drain and done: the compare walks
// one byte pair per cycle through the single read port of the pattern and
// window memories. After the last text byte, emit loads the result register.
// The result register separates the two sides: new input words are taken
// while a result waits; only the next result waits for the old one to drain.
// Reset (synchronous, active low) empties pattern, window and count; no
// memory clearing pass is needed, so the block is ready right after reset.
// Depends on sscnt_pkg, sscnt_ctrl, sscnt_datapath.
module substring_occurrence_counter (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [1:0]               i_action,
    input  logic [7:0]               i_symbol,
    input  logic                     i_last,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [sscnt_pkg::CW-1:0] o_match_count
);
    import sscnt_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    sscnt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_last      (i_last),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    sscnt_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_symbol      (i_symbol),
        .o_stat        (stat),
        .o_match_count (o_match_count)
    );

    // A result is loaded only into a free or draining output register
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (!o_out_valid || i_out_ready))
        else $error("result loaded over an untaken result");

    // A loaded result is presented on the next cycle
    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |=> o_out_valid)
        else $error("loaded result not presented");

    // No input word is taken while a compare pass reads the memories
    a_no_accept_in_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> !cmd.rd_en)
        else $error("input taken during compare pass");

endmodule

/* rtl/core/sscnt_datapath.sv */
// sscnt_datapath: pattern memory, circular text window memory, lengths,
// byte compare pipeline, occurrence counter and result register.
// Depends on sscnt_pkg.
module sscnt_datapath (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  sscnt_pkg::t_cmd         i_cmd,
    input  logic [7:0]              i_symbol,
    output sscnt_pkg::t_stat        o_stat,
    output logic [sscnt_pkg::CW-1:0] o_match_count
);
    import sscnt_pkg::*;

    // Memories
    logic [7:0] pat_mem [MAX_PATTERN];
    logic [7:0] txt_mem [TXT_DEPTH];

    // Control registers
    logic [LW-1:0] r_len;
    logic [LW-1:0] r_fill;
    logic [AW-1:0] r_wp;
    logic [CW-1:0] r_cnt;
    logic          r_rd_v;
    logic          r_mism;

    // Payload registers
    logic [7:0]    r_pat_q;
    logic [7:0]    r_txt_q;
    logic [CW-1:0] r_out;

    logic [AW-1:0] txt_raddr;

    // Window byte paired with pattern byte i sits len-1-i behind the newest
    assign txt_raddr = r_wp - r_len[AW-1:0] + i_cmd.rd_idx;

    // Status
    assign o_stat.can_match = (r_len != '0) && (r_fill >= r_len);
    assign o_stat.last_rd   = ({1'b0, i_cmd.rd_idx} == (r_len - LW'(1)));
    assign o_stat.mismatch  = r_mism;
    assign o_match_count    = r_out;

    // Pattern memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.pat_wr && (r_len < LEN_MAX)) begin
            pat_mem[r_len[AW-1:0]] <= i_symbol;
        end
        r_pat_q <= pat_mem[i_cmd.rd_idx];
    end

    // Text window memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.txt_wr) begin
            txt_mem[r_wp] <= i_symbol;
        end
        r_txt_q <= txt_mem[txt_raddr];
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= r_cnt;
        end
    end

    // Lengths, pointer, counter, compare flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_fill <= '0;
            r_wp   <= '0;
            r_cnt  <= '0;
            r_rd_v <= 1'b0;
            r_mism <= 1'b0;
        end else begin
            r_rd_v <= i_cmd.rd_en;
            if (i_cmd.cmp_clear) begin
                r_mism <= 1'b0;
            end else if (r_rd_v && (r_pat_q != r_txt_q)) begin
                r_mism <= 1'b1;
            end
            if (i_cmd.clear) begin
                r_len  <= '0;
                r_fill <= '0;
                r_cnt  <= '0;
            end else begin
                if (i_cmd.pat_wr && (r_len < LEN_MAX)) begin
                    r_len <= r_len + LW'(1);
                end
                if (i_cmd.txt_wr) begin
                    r_wp <= r_wp + AW'(1);
                    if (r_fill < LEN_MAX) begin
                        r_fill <= r_fill + LW'(1);
                    end
                end
                if (i_cmd.emit) begin
                    r_cnt  <= '0;
                    r_fill <= '0;
                end else if (i_cmd.inc && (r_cnt != CNT_MAX)) begin
                    r_cnt <= r_cnt + CW'(1);
                end
            end
        end
    end

endmodule

/* rtl/core/sscnt_ctrl.sv */
// sscnt_ctrl: state machine that takes input words, sequences the
// byte-serial compare pass and hands results to the output register.
// Depends on sscnt_pkg.
module sscnt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_action,
    input  logic              i_last,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  sscnt_pkg::t_stat  i_stat,
    output sscnt_pkg::t_cmd   o_cmd
);
    import sscnt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_CMP,
        S_DRAIN,
        S_DONE,
        S_EMIT
    } t_state;

    t_state        r_state;
    logic [AW-1:0] r_idx;
    logic          r_last;
    logic          r_cmp;
    logic          r_out_valid;
    logic          in_acc;
    t_action       act;

    assign act         = t_action'(i_action);
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    // Command decode
    always_comb begin
        o_cmd        = '0;
        o_cmd.rd_idx = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (act)
                        ACT_CLEAR:   o_cmd.clear  = 1'b1;
                        ACT_PATTERN: o_cmd.pat_wr = 1'b1;
                        ACT_TEXT:    o_cmd.txt_wr = 1'b1;
                        default:     ;
                    endcase
                end
            end
            S_START: o_cmd.cmp_clear = i_stat.can_match;
            S_CMP:   o_cmd.rd_en     = 1'b1;
            S_DRAIN: ;
            S_DONE:  o_cmd.inc       = r_cmp && !i_stat.mismatch;
            S_EMIT:  o_cmd.emit      = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_last      <= 1'b0;
            r_cmp       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && (act == ACT_TEXT)) begin
                        r_last  <= i_last;
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_idx   <= '0;
                    r_cmp   <= i_stat.can_match;
                    r_state <= i_stat.can_match ? S_CMP : S_DONE;
                end
                S_CMP: begin
                    r_idx <= r_idx + AW'(1);
                    if (i_stat.last_rd) begin
                        r_state <= S_DRAIN;
                    end
                end
                // last byte pair compares during this cycle
                S_DRAIN: r_state <= S_DONE;
                S_DONE:  r_state <= r_last ? S_EMIT : S_IDLE;
                S_EMIT: begin
                    if (o_cmd.emit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
